// ----- rtl/ctt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ctt_pkg;

    // Port field widths
    localparam int OPCODE_W = 2;
    localparam int ACTION_W = 8;
    localparam int TAG_W    = 16;
    localparam int DELAY_W  = 16;
    localparam int DELTA_W  = 16;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int ACTIVE_W = 6;

    // Operation codes
    localparam logic [OPCODE_W-1:0] OP_ARM        = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_LENGTHEN   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_EXTINGUISH = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_TICK       = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;

    // Kind value of an empty slot
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;

    // Controller to datapath
    typedef struct packed {
        logic load;    // capture the command fields, rewind the scan
        logic issue;   // read the slot at the scan index, advance
        logic eval;    // evaluate the slot read last cycle
        logic finish;  // emit the final result of the command
    } ctt_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic noop;      // arm of kind zero, nothing to scan
        logic hit;       // arm/lengthen/extinguish found its slot
        logic idx_end;   // every slot has been read
        logic s1_valid;  // a slot read is waiting for evaluation
    } ctt_sts_t;

endpackage

`default_nettype wire

// ----- rtl/countdown_timer_table.sv -----
// Channel   | Handshake          | Signals
// ----------+--------------------+---------------------------------------------
// command   | start && !busy     | opcode, action_id, arg_tag, delay, delta, kind
// result    | done (one cycle)   | fired, fired_action, fired_tag, status,
//           |                    | active_count, last
//
// One command at a time; the scan reads one slot per cycle, writes it back the next.
// Arm, lengthen and extinguish stop at the first match. A tick scans every slot.
// The final result comes in the same cycle that busy drops, and the next command can
// be taken in that same cycle.
// Reset empties every slot at once. The receiver cannot stall the results.
`timescale 1ns / 1ps
`default_nettype none

module countdown_timer_table #(
    parameter int SLOTS       = 32,
    parameter int ID_WIDTH    = 8,
    parameter int TAG_WIDTH   = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [ctt_pkg::OPCODE_W-1:0]       opcode,
    input  logic [ctt_pkg::ACTION_W-1:0]       action_id,
    input  logic [ctt_pkg::TAG_W-1:0]          arg_tag,
    input  logic [ctt_pkg::DELAY_W-1:0]        delay,
    input  logic signed [ctt_pkg::DELTA_W-1:0] delta,
    input  logic [ctt_pkg::KIND_W-1:0]         kind,
    output logic                               done,
    output logic                               fired,
    output logic [ctt_pkg::ACTION_W-1:0]       fired_action,
    output logic [ctt_pkg::TAG_W-1:0]          fired_tag,
    output logic [ctt_pkg::STATUS_W-1:0]       status,
    output logic [ctt_pkg::ACTIVE_W-1:0]       active_count,
    output logic                               last
);
    import ctt_pkg::*;

    ctt_cmd_t cmd;
    ctt_sts_t sts;

    // Sequencer
    ctt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Slot storage and scan datapath
    ctt_datapath #(
        .SLOTS       (SLOTS),
        .ID_WIDTH    (ID_WIDTH),
        .TAG_WIDTH   (TAG_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .opcode       (opcode),
        .action_id    (action_id),
        .arg_tag      (arg_tag),
        .delay        (delay),
        .delta        (delta),
        .kind         (kind),
        .done         (done),
        .fired        (fired),
        .fired_action (fired_action),
        .fired_tag    (fired_tag),
        .status       (status),
        .active_count (active_count),
        .last         (last)
    );

endmodule

`default_nettype wire

// ----- rtl/ctt_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ctt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  ctt_pkg::ctt_sts_t sts,
    output ctt_pkg::ctt_cmd_t cmd,
    output logic              busy
);
    import ctt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.eval = 1'b1;
                if (sts.noop || sts.hit)
                begin
                    state_next = S_FINISH;
                end
                else if (!sts.idx_end)
                begin
                    cmd.issue = 1'b1;
                end
                else if (!sts.s1_valid)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

// ----- rtl/ctt_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ctt_datapath #(
    parameter int SLOTS       = 32,
    parameter int ID_WIDTH    = 8,
    parameter int TAG_WIDTH   = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  ctt_pkg::ctt_cmd_t                        cmd,
    output ctt_pkg::ctt_sts_t                        sts,
    input  logic [ctt_pkg::OPCODE_W-1:0]             opcode,
    input  logic [ctt_pkg::ACTION_W-1:0]             action_id,
    input  logic [ctt_pkg::TAG_W-1:0]                arg_tag,
    input  logic [ctt_pkg::DELAY_W-1:0]              delay,
    input  logic signed [ctt_pkg::DELTA_W-1:0]       delta,
    input  logic [ctt_pkg::KIND_W-1:0]               kind,
    output logic                                     done,
    output logic                                     fired,
    output logic [ctt_pkg::ACTION_W-1:0]             fired_action,
    output logic [ctt_pkg::TAG_W-1:0]                fired_tag,
    output logic [ctt_pkg::STATUS_W-1:0]             status,
    output logic [ctt_pkg::ACTIVE_W-1:0]             active_count,
    output logic                                     last
);
    import ctt_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int EW    = (COUNT_WIDTH > DELAY_W) ? COUNT_WIDTH : DELAY_W;
    localparam int SW    = COUNT_WIDTH + DELTA_W + 2;
    localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

    // Captured command fields
    logic [OPCODE_W-1:0]       op_reg;
    logic [ID_WIDTH-1:0]       id_reg;
    logic [TAG_WIDTH-1:0]      tag_reg;
    logic [DELAY_W-1:0]        delay_reg;
    logic signed [DELTA_W-1:0] delta_reg;
    logic [KIND_W-1:0]         kind_reg;

    // Scan control
    logic [IDX_W:0]     rd_idx_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic               s1_valid_reg;
    logic               found_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    // Slot storage: kinds in flops (reset to empty), the rest in memory
    logic [KIND_W-1:0]      kind_mem_reg [SLOTS];
    logic [ID_WIDTH-1:0]    action_mem   [SLOTS];
    logic [TAG_WIDTH-1:0]   tag_mem      [SLOTS];
    logic [COUNT_WIDTH-1:0] rem_mem      [SLOTS];

    // Slot under evaluation
    logic [IDX_W-1:0]       s1_slot_reg;
    logic [KIND_W-1:0]      s1_kind_reg;
    logic [ID_WIDTH-1:0]    s1_action_reg;
    logic [TAG_WIDTH-1:0]   s1_tag_reg;
    logic [COUNT_WIDTH-1:0] s1_rem_reg;

    // Fired timer held until it is known whether it is the last one
    logic                 pend_valid_reg;
    logic [ID_WIDTH-1:0]  pend_action_reg;
    logic [TAG_WIDTH-1:0] pend_tag_reg;
    logic [CNT_W-1:0]     pend_count_reg;

    // Result registers
    logic                 done_reg;
    logic                 done_next;
    logic                 fired_reg,   fired_next;
    logic [ACTION_W-1:0]  action_reg,  action_next;
    logic [TAG_W-1:0]     ftag_reg,    ftag_next;
    logic [STATUS_W-1:0]  status_reg,  status_next;
    logic [ACTIVE_W-1:0]  active_reg,  active_next;
    logic                 last_reg,    last_next;

    // Evaluation terms
    logic                   ev;
    logic                   is_empty;
    logic                   id_match;
    logic                   arm_hit;
    logic                   len_hit;
    logic                   ext_hit;
    logic                   tick_match;
    logic                   tick_fire;
    logic                   kind_set;
    logic                   kind_clr;
    logic                   rem_we;
    logic [COUNT_WIDTH-1:0] rem_wdata;
    logic [EW-1:0]          dly_ext;
    logic [COUNT_WIDTH-1:0] dly_sat;
    logic signed [SW-1:0]   sum_s;
    logic [COUNT_WIDTH-1:0] len_val;
    logic [STATUS_W-1:0]    final_status;

    assign rd_addr = rd_idx_reg[IDX_W-1:0];

    // Capture the command on a transfer
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= opcode;
            id_reg    <= ID_WIDTH'(action_id);
            tag_reg   <= TAG_WIDTH'(arg_tag);
            delay_reg <= delay;
            delta_reg <= delta;
            kind_reg  <= kind;
        end
    end

    // Slot matching
    always_comb
    begin
        ev         = cmd.eval && s1_valid_reg;
        is_empty   = (s1_kind_reg == KIND_NONE);
        id_match   = !is_empty && (s1_action_reg == id_reg);
        arm_hit    = (op_reg == OP_ARM) && is_empty;
        len_hit    = (op_reg == OP_LENGTHEN) && id_match;
        ext_hit    = (op_reg == OP_EXTINGUISH) && id_match;
        tick_match = (op_reg == OP_TICK) && (kind_reg != KIND_NONE)
                     && (s1_kind_reg == kind_reg)
                     && (s1_rem_reg != '0);
        tick_fire  = tick_match && (s1_rem_reg == COUNT_WIDTH'(1));
        kind_set   = ev && arm_hit;
        kind_clr   = ev && (ext_hit || tick_fire);
    end

    // Status to the controller
    always_comb
    begin
        sts.noop     = (op_reg == OP_ARM) && (kind_reg == KIND_NONE);
        sts.hit      = s1_valid_reg && (arm_hit || len_hit || ext_hit);
        sts.idx_end  = (rd_idx_reg == (IDX_W + 1)'(SLOTS));
        sts.s1_valid = s1_valid_reg;
    end

    // Saturated arm delay and lengthen sum
    always_comb
    begin
        dly_ext = EW'(delay_reg);
        if (dly_ext > EW'(CMAX))
        begin
            dly_sat = CMAX;
        end
        else
        begin
            dly_sat = COUNT_WIDTH'(dly_ext);
        end

        sum_s = $signed({{(SW - COUNT_WIDTH){1'b0}}, s1_rem_reg})
              + $signed({{(SW - DELTA_W){delta_reg[DELTA_W-1]}}, delta_reg});
        if (sum_s[SW-1])
        begin
            len_val = '0;
        end
        else if (|sum_s[SW-2:COUNT_WIDTH])
        begin
            len_val = CMAX;
        end
        else
        begin
            len_val = sum_s[COUNT_WIDTH-1:0];
        end
    end

    // Remaining count write-back
    always_comb
    begin
        rem_we    = ev && (arm_hit || len_hit || tick_match);
        rem_wdata = s1_rem_reg - COUNT_WIDTH'(1);
        if (arm_hit)
        begin
            rem_wdata = dly_sat;
        end
        else if (len_hit)
        begin
            rem_wdata = len_val;
        end
    end

    // Slot memories: one read at the scan index, one write at the evaluated slot
    always_ff @(posedge clk)
    begin
        if (kind_set)
        begin
            action_mem[s1_slot_reg] <= id_reg;
            tag_mem[s1_slot_reg]    <= tag_reg;
        end
        if (rem_we)
        begin
            rem_mem[s1_slot_reg] <= rem_wdata;
        end
        if (cmd.issue)
        begin
            s1_action_reg <= action_mem[rd_addr];
            s1_tag_reg    <= tag_mem[rd_addr];
            s1_rem_reg    <= rem_mem[rd_addr];
            s1_kind_reg   <= kind_mem_reg[rd_addr];
            s1_slot_reg   <= rd_addr;
        end
    end

    // Slot kinds, empty after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                kind_mem_reg[i] <= KIND_NONE;
            end
        end
        else if (kind_set)
        begin
            kind_mem_reg[s1_slot_reg] <= kind_reg;
        end
        else if (kind_clr)
        begin
            kind_mem_reg[s1_slot_reg] <= KIND_NONE;
        end
    end

    // Occupied count
    always_comb
    begin
        count_next = count_reg;
        if (kind_set)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (kind_clr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Scan index and control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg     <= '0;
            s1_valid_reg   <= 1'b0;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            count_reg      <= '0;
        end
        else
        begin
            count_reg    <= count_next;
            s1_valid_reg <= cmd.issue;
            if (cmd.load)
            begin
                rd_idx_reg     <= '0;
                found_reg      <= 1'b0;
                pend_valid_reg <= 1'b0;
            end
            else
            begin
                if (cmd.issue)
                begin
                    rd_idx_reg <= rd_idx_reg + (IDX_W + 1)'(1);
                end
                if (ev && sts.hit)
                begin
                    found_reg <= 1'b1;
                end
                if (ev && tick_fire)
                begin
                    pend_valid_reg <= 1'b1;
                end
            end
        end
    end

    // Fired timer payload
    always_ff @(posedge clk)
    begin
        if (ev && tick_fire)
        begin
            pend_action_reg <= s1_action_reg;
            pend_tag_reg    <= s1_tag_reg;
            pend_count_reg  <= count_reg - CNT_W'(1);
        end
    end

    // Final status by operation
    always_comb
    begin
        final_status = STAT_OK;
        case (op_reg)
            OP_ARM:
            begin
                if (!sts.noop && !found_reg)
                begin
                    final_status = STAT_FULL;
                end
            end
            OP_LENGTHEN, OP_EXTINGUISH:
            begin
                if (!found_reg)
                begin
                    final_status = STAT_NOT_FOUND;
                end
            end
            default:
            begin
                final_status = STAT_OK;
            end
        endcase
    end

    // Result selection: a held firing goes out when a newer one arrives
    always_comb
    begin
        done_next   = 1'b0;
        fired_next  = fired_reg;
        action_next = action_reg;
        ftag_next   = ftag_reg;
        status_next = status_reg;
        active_next = active_reg;
        last_next   = last_reg;
        if (ev && tick_fire && pend_valid_reg)
        begin
            done_next   = 1'b1;
            fired_next  = 1'b1;
            action_next = ACTION_W'(pend_action_reg);
            ftag_next   = TAG_W'(pend_tag_reg);
            status_next = STAT_OK;
            active_next = ACTIVE_W'(pend_count_reg);
            last_next   = 1'b0;
        end
        else if (cmd.finish)
        begin
            done_next = 1'b1;
            last_next = 1'b1;
            if ((op_reg == OP_TICK) && pend_valid_reg)
            begin
                fired_next  = 1'b1;
                action_next = ACTION_W'(pend_action_reg);
                ftag_next   = TAG_W'(pend_tag_reg);
                status_next = STAT_OK;
                active_next = ACTIVE_W'(pend_count_reg);
            end
            else
            begin
                fired_next  = 1'b0;
                action_next = '0;
                ftag_next   = '0;
                status_next = final_status;
                active_next = ACTIVE_W'(count_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fired_reg  <= fired_next;
        action_reg <= action_next;
        ftag_reg   <= ftag_next;
        status_reg <= status_next;
        active_reg <= active_next;
        last_reg   <= last_next;
    end

    assign done         = done_reg;
    assign fired        = fired_reg;
    assign fired_action = action_reg;
    assign fired_tag    = ftag_reg;
    assign status       = status_reg;
    assign active_count = active_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire

// ----- rtl/ctt_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ctt_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          done,
    input logic                          fired,
    input logic [ctt_pkg::STATUS_W-1:0]  status,
    input logic                          last
);
    import ctt_pkg::*;

    // Firings ahead of the final result come out while the scan runs
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !last) |-> busy)
        else $error("non-final result transfer while idle");

    // The final result comes once the command has ended
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (done && last) |-> !busy)
        else $error("still busy with final result");

    // A command transfer makes the block busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command transfer not taken");

    // A fired timer always reports ok
    a_fired_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && fired) |-> (status == STAT_OK))
        else $error("fired result with error status");

    // Only firings come ahead of the final result
    a_nonlast_fired: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !last) |-> fired)
        else $error("non-final result without a firing");

endmodule

bind countdown_timer_table ctt_checker u_ctt_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .fired  (fired),
    .status (status),
    .last   (last)
);

`default_nettype wire

// ----- test/countdown_timer_table_tb.sv -----
`timescale 1ns / 1ps

module countdown_timer_table_tb;

    import ctt_pkg::*;

    localparam int SLOTS        = 32;
    localparam int COUNT_MAX    = 65535;
    localparam int SCAN_CYCLES  = SLOTS + 3;
    localparam int LIMIT_CYCLES = 400000;
    localparam int MAX_GAP      = 30;

    // One result as the block reports it
    typedef struct packed {
        logic                fired;
        logic [ACTION_W-1:0] action;
        logic [TAG_W-1:0]    tag;
        logic [STATUS_W-1:0] status;
        logic [ACTIVE_W-1:0] count;
        logic                last;
    } timer_result_t;

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      start        = 1'b0;
    logic [OPCODE_W-1:0]       opcode       = '0;
    logic [ACTION_W-1:0]       action_id    = '0;
    logic [TAG_W-1:0]          arg_tag      = '0;
    logic [DELAY_W-1:0]        delay        = '0;
    logic signed [DELTA_W-1:0] delta        = '0;
    logic [KIND_W-1:0]         kind         = '0;
    logic                      busy;
    logic                      done;
    logic                      fired;
    logic [ACTION_W-1:0]       fired_action;
    logic [TAG_W-1:0]          fired_tag;
    logic [STATUS_W-1:0]       status;
    logic [ACTIVE_W-1:0]       active_count;
    logic                      last;

    // Shadow copy of the timer table
    logic [KIND_W-1:0]   tbl_kind [SLOTS];
    logic [ACTION_W-1:0] tbl_action [SLOTS];
    logic [TAG_W-1:0]    tbl_tag [SLOTS];
    logic [DELAY_W-1:0]  tbl_remaining [SLOTS];
    int                  tbl_occupied;

    timer_result_t pending_results[$];

    int sender_idle_pct = 0;
    int errors          = 0;
    int cmds_sent       = 0;
    int results_seen    = 0;
    int fires_seen      = 0;
    int full_seen       = 0;
    int missing_seen    = 0;
    int cycles          = 0;

    countdown_timer_table uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .action_id    (action_id),
        .arg_tag      (arg_tag),
        .delay        (delay),
        .delta        (delta),
        .kind         (kind),
        .done         (done),
        .fired        (fired),
        .fired_action (fired_action),
        .fired_tag    (fired_tag),
        .status       (status),
        .active_count (active_count),
        .last         (last)
    );

    always #10 clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles, %0d results still due", cycles,
                     pending_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Lowest active slot holding this id, -1 if none
    function automatic int find_timer(input logic [ACTION_W-1:0] id);
        for (int i = 0; i < SLOTS; i++)
        begin
            if (tbl_kind[i] != KIND_NONE && tbl_action[i] == id)
                return i;
        end
        return -1;
    endfunction

    // Apply one accepted command to the shadow table and queue its results
    task automatic predict_timer_cmd(input logic [OPCODE_W-1:0] op,
                                     input logic [ACTION_W-1:0] id,
                                     input logic [TAG_W-1:0] tag,
                                     input logic [DELAY_W-1:0] dly,
                                     input logic signed [DELTA_W-1:0] dlt,
                                     input logic [KIND_W-1:0] knd);
        int            slot;
        int            sum;
        int            last_fire;
        timer_result_t r;
        r      = '0;
        r.last = 1'b1;
        slot   = -1;
        case (op)
            OP_ARM:
            begin
                if (knd != KIND_NONE)
                begin
                    for (int i = SLOTS - 1; i >= 0; i--)
                    begin
                        if (tbl_kind[i] == KIND_NONE)
                            slot = i;
                    end
                    if (slot < 0)
                        r.status = STAT_FULL;
                    else
                    begin
                        tbl_kind[slot]      = knd;
                        tbl_action[slot]    = id;
                        tbl_tag[slot]       = tag;
                        tbl_remaining[slot] = dly;
                        tbl_occupied++;
                    end
                end
                r.count = ACTIVE_W'(tbl_occupied);
                pending_results.push_back(r);
            end
            OP_LENGTHEN, OP_EXTINGUISH:
            begin
                slot = find_timer(id);
                if (slot < 0)
                    r.status = STAT_NOT_FOUND;
                else if (op == OP_LENGTHEN)
                begin
                    sum = int'(tbl_remaining[slot]) + int'(dlt);
                    if (sum < 0)
                        sum = 0;
                    if (sum > COUNT_MAX)
                        sum = COUNT_MAX;
                    tbl_remaining[slot] = DELAY_W'(sum);
                end
                else
                begin
                    tbl_kind[slot]      = KIND_NONE;
                    tbl_remaining[slot] = '0;
                    tbl_occupied--;
                end
                r.count = ACTIVE_W'(tbl_occupied);
                pending_results.push_back(r);
            end
            default:
            begin
                // Tick: find the final expiry first so its result carries last
                last_fire = -1;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (knd != KIND_NONE && tbl_kind[i] == knd && tbl_remaining[i] == 1)
                        last_fire = i;
                end
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (knd == KIND_NONE || tbl_kind[i] != knd || tbl_remaining[i] == 0)
                        continue;
                    tbl_remaining[i]--;
                    if (tbl_remaining[i] == 0)
                    begin
                        tbl_kind[i] = KIND_NONE;
                        tbl_occupied--;
                        r.fired  = 1'b1;
                        r.action = tbl_action[i];
                        r.tag    = tbl_tag[i];
                        r.count  = ACTIVE_W'(tbl_occupied);
                        r.last   = (i == last_fire);
                        pending_results.push_back(r);
                    end
                end
                if (last_fire < 0)
                begin
                    r.count = ACTIVE_W'(tbl_occupied);
                    pending_results.push_back(r);
                end
            end
        endcase
    endtask

    // One command transfer; start may stay high into the next call
    task automatic send_cmd(input logic [OPCODE_W-1:0] op,
                            input logic [ACTION_W-1:0] id,
                            input logic [TAG_W-1:0] tag,
                            input logic [DELAY_W-1:0] dly,
                            input logic signed [DELTA_W-1:0] dlt,
                            input logic [KIND_W-1:0] knd);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct)
            gap++;
        @(negedge clk);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        opcode    = op;
        action_id = id;
        arg_tag   = tag;
        delay     = dly;
        delta     = dlt;
        kind      = knd;
        start     = 1'b1;
        do
            @(posedge clk);
        while (busy);
        predict_timer_cmd(op, id, tag, dly, dlt, knd);
        cmds_sent++;
    endtask

    // Hold off until every queued result has been seen
    task automatic wait_for_results();
        @(negedge clk);
        start = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Result checker
    always @(posedge clk)
    begin
        timer_result_t want;
        timer_result_t got;
        if (rst_n && done)
        begin
            got = {fired, fired_action, fired_tag, status, active_count, last};
            results_seen++;
            if (fired)
                fires_seen++;
            if (status == STAT_FULL)
                full_seen++;
            if (status == STAT_NOT_FOUND)
                missing_seen++;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result fired=%0b action=%0h tag=%0h",
                         $time, fired, fired_action, fired_tag);
                $display("%0t:   status=%0d count=%0d last=%0b",
                         $time, status, active_count, last);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.fired !== want.fired)
                begin
                    errors++;
                    $display("%0t: fired expected %0b actual %0b", $time, want.fired, got.fired);
                end
                if (got.action !== want.action)
                begin
                    errors++;
                    $display("%0t: fired_action expected %0h actual %0h", $time, want.action,
                             got.action);
                end
                if (got.tag !== want.tag)
                begin
                    errors++;
                    $display("%0t: fired_tag expected %0h actual %0h", $time, want.tag, got.tag);
                end
                if (got.status !== want.status)
                begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d", $time, want.status,
                             got.status);
                end
                if (got.count !== want.count)
                begin
                    errors++;
                    $display("%0t: active_count expected %0d actual %0d", $time, want.count,
                             got.count);
                end
                if (got.last !== want.last)
                begin
                    errors++;
                    $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
                end
            end
        end
    end

    // Edge cases: kind zero, zero delay, extremes, saturation, duplicate ids
    task automatic test_corner_cases();
        send_cmd(OP_ARM, 8'h00, 16'h0000, 16'h0000, 16'sh0000, KIND_NONE);
        send_cmd(OP_TICK, 8'hFF, 16'hFFFF, 16'hFFFF, -16'sd1, KIND_NONE);
        send_cmd(OP_ARM, 8'hFF, 16'hFFFF, 16'hFFFF, 16'sh7FFF, 2'd3);
        send_cmd(OP_ARM, 8'h00, 16'h0000, 16'h0000, 16'sh0000, 2'd1);
        send_cmd(OP_ARM, 8'h12, 16'hA5A5, 16'h0001, 16'sh0000, 2'd2);
        // zero timer must not fire
        send_cmd(OP_TICK, 8'h00, 16'h0000, 16'h0000, 16'sh0000, 2'd1);
        send_cmd(OP_TICK, 8'h5A, 16'h5A5A, 16'h5A5A, 16'sh5A5A, 2'd2);
        // saturate high, then low, then revive from zero
        send_cmd(OP_LENGTHEN, 8'hFF, 16'h0000, 16'h0000, 16'sh7FFF, 2'd0);
        send_cmd(OP_LENGTHEN, 8'hFF, 16'h0000, 16'h0000, -16'sd32768, 2'd0);
        send_cmd(OP_LENGTHEN, 8'hFF, 16'h0000, 16'h0000, -16'sd32768, 2'd0);
        send_cmd(OP_TICK, 8'h00, 16'h0000, 16'h0000, 16'sh0000, 2'd3);
        send_cmd(OP_LENGTHEN, 8'hFF, 16'h0000, 16'h0000, 16'sd2, 2'd0);
        send_cmd(OP_TICK, 8'h00, 16'h0000, 16'h0000, 16'sh0000, 2'd3);
        send_cmd(OP_TICK, 8'h00, 16'h0000, 16'h0000, 16'sh0000, 2'd3);
        // unknown id
        send_cmd(OP_LENGTHEN, 8'h77, 16'h0000, 16'h0000, 16'sd5, 2'd1);
        send_cmd(OP_EXTINGUISH, 8'h77, 16'h0000, 16'h0000, 16'sh0000, 2'd1);
        send_cmd(OP_EXTINGUISH, 8'h00, 16'h0000, 16'h0000, 16'sh0000, 2'd1);
        // same id twice: extinguish takes the lower slot
        send_cmd(OP_ARM, 8'h40, 16'h1234, 16'h0003, 16'sh0000, 2'd1);
        send_cmd(OP_ARM, 8'h40, 16'h4321, 16'h0001, 16'sh0000, 2'd2);
        send_cmd(OP_EXTINGUISH, 8'h40, 16'h0000, 16'h0000, 16'sh0000, 2'd3);
        send_cmd(OP_TICK, 8'h00, 16'h0000, 16'h0000, 16'sh0000, 2'd1);
        send_cmd(OP_TICK, 8'h00, 16'h0000, 16'h0000, 16'sh0000, 2'd2);
    endtask

    // Fill every slot, overflow once, then expire the lot in two ticks
    task automatic test_table_full();
        for (int i = 0; i <= SLOTS; i++)
            send_cmd(OP_ARM, ACTION_W'($urandom_range(255)), TAG_W'($urandom_range(65535)),
                     DELAY_W'($urandom_range(1, 2)), 16'sh0000, 2'd1);
        send_cmd(OP_TICK, ACTION_W'($urandom_range(255)), TAG_W'($urandom_range(65535)),
                 DELAY_W'($urandom_range(65535)), DELTA_W'($urandom_range(65535)), 2'd1);
        send_cmd(OP_TICK, ACTION_W'($urandom_range(255)), TAG_W'($urandom_range(65535)),
                 DELAY_W'($urandom_range(65535)), DELTA_W'($urandom_range(65535)), 2'd1);
    endtask

    // Mostly small ids and short delays so lookups hit and ticks fire
    task automatic test_random_traffic(input int n_items);
        int                        pick;
        logic [OPCODE_W-1:0]       op;
        logic [ACTION_W-1:0]       id;
        logic [DELAY_W-1:0]        dly;
        logic signed [DELTA_W-1:0] dlt;
        logic [KIND_W-1:0]         knd;
        for (int n = 0; n < n_items; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
                op = OP_ARM;
            else if (pick < 50)
                op = OP_LENGTHEN;
            else if (pick < 65)
                op = OP_EXTINGUISH;
            else
                op = OP_TICK;
            id = ($urandom_range(99) < 80) ? ACTION_W'($urandom_range(15))
                                           : ACTION_W'($urandom_range(255));
            pick = $urandom_range(99);
            if (pick < 75)
                dly = DELAY_W'($urandom_range(6));
            else if (pick < 90)
                dly = DELAY_W'($urandom_range(300));
            else
                dly = DELAY_W'($urandom_range(65535));
            if ($urandom_range(99) < 70)
                dlt = DELTA_W'(int'($urandom_range(10)) - 4);
            else
                dlt = DELTA_W'($urandom_range(65535));
            knd = ($urandom_range(99) < 10) ? KIND_NONE : KIND_W'($urandom_range(1, 3));
            send_cmd(op, id, TAG_W'($urandom_range(65535)), dly, dlt, knd);
        end
    endtask

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_kind[i]      = KIND_NONE;
            tbl_action[i]    = '0;
            tbl_tag[i]       = '0;
            tbl_remaining[i] = '0;
        end
        tbl_occupied = 0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        sender_idle_pct = 38;
        test_corner_cases();
        test_table_full();
        test_random_traffic(65);
        wait_for_results();

        sender_idle_pct = 86;
        test_random_traffic(65);
        wait_for_results();

        sender_idle_pct = 0;
        test_random_traffic(65);
        wait_for_results();
        repeat (SCAN_CYCLES + 5) @(posedge clk);

        $display("Covered %0d commands, %0d results: %0d expiries, %0d full, %0d not found",
                 cmds_sent, results_seen, fires_seen, full_seen, missing_seen);
        $display("Sender gaps of 38%%, 86%% and none; %0d errors", errors);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
